// ===== src/ege_pkg.sv =====
// Package: shared types, constants and state codes for the elliptical erosion block.
`default_nettype none
package ege_pkg;

  localparam int MAX_WIDTH    = 2048;
  localparam int MAX_RADIUS_X = 15;
  localparam int MAX_RADIUS_Y = 15;
  localparam int PIXEL_BITS   = 16;

  localparam int COL_BITS  = $clog2(MAX_WIDTH);
  localparam int RING_ROWS = 2 * MAX_RADIUS_Y + MAX_RADIUS_X + 2;
  localparam int RING_BITS = $clog2(RING_ROWS);
  localparam int MEM_DEPTH = RING_ROWS * MAX_WIDTH;
  localparam int ADDR_BITS = RING_BITS + COL_BITS;
  localparam int HSLOTS    = MAX_RADIUS_X + 1;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_RAD_H        = 3'd0,
    REG_RAD_V        = 3'd1,
    REG_EDGE_REP     = 3'd2,
    REG_FRAME_WIDTH  = 3'd3,
    REG_FRAME_HEIGHT = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] pixel_in;
    logic        drain;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pixel_out;
    logic        frame_end;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  rad_h;
    logic [3:0]  rad_v;
    logic        edge_rep;
    logic [11:0] frame_width;
    logic [11:0] frame_height;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_OPEN,
    S_SETUP,
    S_H_T2,
    S_H_V,
    S_H_N,
    S_H_Q,
    S_H_R,
    S_STORE,
    S_DECIDE,
    S_SCAN,
    S_LAST,
    S_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic open;
    logic setup;
    logic h_t2;
    logic h_v;
    logic h_n;
    logic h_q;
    logic h_r;
    logic store;
    logic scan_init;
    logic scan;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic frame_open;
    logic n_done;
    logic hgt_last;
    logic want_out;
    logic scan_last;
    logic out_free;
    logic pend;
  } sts_t;

endpackage
`default_nettype wire

// ===== src/ege_ctrl.sv =====
// Controller: sequences frame opening, height computation, store, window scan and emit.
`default_nettype none
module ege_ctrl
  import ege_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic in_drain,
  output logic      in_ready,
  input  sts_t      sts,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (!in_drain && !sts.frame_open) state_nxt = S_OPEN;
          else if (sts.frame_open)          state_nxt = S_STORE;
        end
      end
      S_OPEN: begin
        cmd.open  = 1'b1;
        state_nxt = S_SETUP;
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = S_H_T2;
      end
      S_H_T2: begin
        cmd.h_t2  = 1'b1;
        state_nxt = S_H_V;
      end
      S_H_V: begin
        cmd.h_v   = 1'b1;
        state_nxt = S_H_N;
      end
      S_H_N: begin
        cmd.h_n = 1'b1;
        if (sts.n_done) state_nxt = S_H_Q;
      end
      S_H_Q: begin
        cmd.h_q   = 1'b1;
        state_nxt = S_H_R;
      end
      S_H_R: begin
        cmd.h_r   = 1'b1;
        state_nxt = sts.hgt_last ? S_STORE : S_H_T2;
      end
      S_STORE: begin
        cmd.store = 1'b1;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.want_out) begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_nxt = S_LAST;
      end
      S_LAST: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/ege_datapath.sv =====
// Datapath: frame settings, height unit, line store ring, window scan and output register.
`default_nettype none
module ege_datapath
  import ege_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  cfg_t      cfg,
  input  in_item_t  in_data,
  input  cmd_t      cmd,
  output sts_t      sts,
  output out_item_t out_data,
  output logic      out_valid,
  input  wire logic out_ready
);

  localparam logic [RING_BITS-1:0] RING_LAST = RING_BITS'(RING_ROWS - 1);
  localparam logic [RING_BITS+1:0] RING_N    = (RING_BITS+2)'(RING_ROWS);

  // captured item
  logic [15:0] pix_r;
  logic        drain_r;

  // latched frame settings
  logic [3:0]  f_rx_r, f_ry_r;
  logic        f_edge_r;
  logic [11:0] f_w_r, f_h_r;
  logic [22:0] f_total_r;
  logic [15:0] f_delay_r;
  logic        open_r;

  // height unit
  logic [7:0]  ry2_r;
  logic [9:0]  rx4sq_r, dsq_r;
  logic [3:0]  a_r;
  logic [9:0]  t2_r;
  logic [19:0] v_r, s_r, inc_r;
  logic [4:0]  n_r;
  logic [8:0]  q_r;
  logic [3:0]  hgt_r [HSLOTS];

  // stream counters
  logic [22:0]          in_cnt_r, out_cnt_r;
  logic [COL_BITS-1:0]  in_col_r, out_col_r;
  logic [RING_BITS-1:0] in_ring_r, out_ring_r;
  logic [11:0]          out_row_r;

  // scan
  logic signed [5:0] dx_r, dy_r;
  logic [3:0]        cur_h_r;
  logic [15:0]       min_r;
  logic              pend_r, zero_r;
  logic [15:0]       rd_r;

  // output register
  out_item_t out_r;
  logic      out_valid_r;

  logic [PIXEL_BITS-1:0] mem [MEM_DEPTH];

  // clamped configuration
  logic [3:0]  c_rx, c_ry;
  logic [11:0] c_w, c_h;
  always_comb begin
    c_rx = (cfg.rad_h == 4'd0) ? 4'd1 : cfg.rad_h;
    c_ry = (cfg.rad_v == 4'd0) ? 4'd1 : cfg.rad_v;
    c_h  = (cfg.frame_height == 12'd0) ? 12'd1 : cfg.frame_height;
    if (cfg.frame_width == 12'd0)                 c_w = 12'd1;
    else if (cfg.frame_width > 12'(MAX_WIDTH))    c_w = 12'(MAX_WIDTH);
    else                                          c_w = cfg.frame_width;
  end

  // height unit arithmetic
  logic [4:0]  two_a_m1;
  logic [17:0] qq;
  logic        round_up;
  logic [4:0]  n_fin;
  always_comb begin
    two_a_m1 = {a_r, 1'b0} - 5'd1;
    qq       = 18'(q_r * q_r);
    round_up = (20'(qq) < v_r) || ((20'(qq) == v_r) && n_r[0]);
    n_fin    = round_up ? n_r + 5'd1 : n_r;
  end

  // next-column height lookup for the scan
  logic signed [5:0] dx_next;
  logic [3:0]        abs_next;
  logic [3:0]        h_next;
  always_comb begin
    dx_next  = cmd.scan_init ? -$signed({2'b00, f_rx_r}) : dx_r + 6'sd1;
    abs_next = dx_next[5] ? 4'(-dx_next) : dx_next[3:0];
    h_next   = hgt_r[abs_next];
  end

  // window address for the current offset
  logic signed [13:0] r_s, dyeff;
  logic signed [12:0] c_s;
  logic               row_lo, row_hi, col_lo, col_hi;
  logic signed [7:0]  rs;
  logic [RING_BITS-1:0] ring_rd;
  logic [COL_BITS-1:0]  col_rd;
  always_comb begin
    r_s    = $signed({2'b00, out_row_r}) + 14'(dy_r);
    c_s    = $signed({2'b00, out_col_r}) + 13'(dx_r);
    row_lo = r_s < 14'sd0;
    row_hi = r_s >= $signed({2'b00, f_h_r});
    col_lo = c_s < 13'sd0;
    col_hi = c_s >= $signed({1'b0, f_w_r});
    if (row_lo)      dyeff = -$signed({2'b00, out_row_r});
    else if (row_hi) dyeff = $signed({2'b00, f_h_r}) - 14'sd1 - $signed({2'b00, out_row_r});
    else             dyeff = 14'(dy_r);
    rs = $signed({2'b00, out_ring_r}) + dyeff[7:0];
    if (rs < 8'sd0)                        ring_rd = RING_BITS'(rs + $signed(8'(RING_N)));
    else if (rs >= $signed(8'(RING_N)))    ring_rd = RING_BITS'(rs - $signed(8'(RING_N)));
    else                                   ring_rd = rs[RING_BITS-1:0];
    if (col_lo)      col_rd = '0;
    else if (col_hi) col_rd = COL_BITS'(f_w_r - 12'd1);
    else             col_rd = c_s[COL_BITS-1:0];
  end

  // running minimum with the pending read
  logic [15:0] rd_val, min_upd;
  always_comb begin
    rd_val  = zero_r ? 16'd0 : rd_r;
    min_upd = (pend_r && rd_val < min_r) ? rd_val : min_r;
  end

  logic        store_ok, in_last_col, out_last_col, out_last;
  logic [22:0] in_cnt_inc;
  always_comb begin
    store_ok     = !drain_r && (in_cnt_r < f_total_r);
    in_cnt_inc   = in_cnt_r + 23'd1;
    in_last_col  = ({1'b0, in_col_r} + 12'd1) == f_w_r;
    out_last_col = ({1'b0, out_col_r} + 12'd1) == f_w_r;
    out_last     = (out_cnt_r + 23'd1) == f_total_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r      <= 1'b0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      pend_r <= cmd.scan;
      if (cmd.open) open_r <= 1'b1;
      else if (cmd.emit && out_last) open_r <= 1'b0;
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // payload and counter registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pix_r   <= in_data.pixel_in;
      drain_r <= in_data.drain;
    end
    if (cmd.open) begin
      f_rx_r   <= c_rx;
      f_ry_r   <= c_ry;
      f_edge_r <= cfg.edge_rep;
      f_w_r    <= c_w;
      f_h_r    <= c_h;
    end
    if (cmd.setup) begin
      f_total_r  <= 23'(f_w_r * f_h_r);
      f_delay_r  <= 16'(f_ry_r * f_w_r) + 16'(f_rx_r);
      ry2_r      <= 8'(f_ry_r * f_ry_r);
      rx4sq_r    <= 10'({f_rx_r, 1'b0} * {f_rx_r, 1'b0});
      dsq_r      <= 10'({f_rx_r, 1'b0} * {f_rx_r, 1'b0});
      a_r        <= '0;
      in_cnt_r   <= '0;
      out_cnt_r  <= '0;
      in_col_r   <= '0;
      out_col_r  <= '0;
      in_ring_r  <= '0;
      out_ring_r <= '0;
      out_row_r  <= '0;
    end
    if (cmd.h_t2) t2_r <= (a_r == 4'd0) ? 10'd0 : 10'(two_a_m1 * two_a_m1);
    if (cmd.h_v) begin
      v_r   <= 20'(ry2_r * (rx4sq_r - t2_r));
      n_r   <= '0;
      s_r   <= 20'(dsq_r);
      inc_r <= 20'(dsq_r) * 20'd3;
    end
    if (cmd.h_n && s_r <= v_r) begin
      n_r   <= n_r + 5'd1;
      s_r   <= s_r + inc_r;
      inc_r <= inc_r + {9'd0, dsq_r, 1'b0};
    end
    if (cmd.h_q) q_r <= 9'(({n_r, 1'b0} + 6'd1) * f_rx_r);
    if (cmd.h_r) begin
      hgt_r[a_r] <= n_fin[3:0];
      a_r        <= a_r + 4'd1;
    end
    if (cmd.store && store_ok) begin
      in_cnt_r <= in_cnt_inc;
      if (in_last_col) begin
        in_col_r  <= '0;
        in_ring_r <= (in_ring_r == RING_LAST) ? '0 : in_ring_r + 1'b1;
      end else begin
        in_col_r <= in_col_r + 1'b1;
      end
    end
    // scan stepping: dy runs -h..h inside each column dx
    if (cmd.scan_init) begin
      dx_r    <= dx_next;
      dy_r    <= -$signed({2'b00, h_next});
      cur_h_r <= h_next;
      min_r   <= '1;
    end else begin
      min_r <= min_upd;
    end
    if (cmd.scan) begin
      zero_r <= (row_lo || row_hi || col_lo || col_hi) && !f_edge_r;
      if (dy_r == $signed({2'b00, cur_h_r})) begin
        dx_r    <= dx_next;
        dy_r    <= -$signed({2'b00, h_next});
        cur_h_r <= h_next;
      end else begin
        dy_r <= dy_r + 6'sd1;
      end
    end
    if (cmd.emit) begin
      out_r.pixel_out <= min_r;
      out_r.frame_end <= out_last;
      out_cnt_r       <= out_cnt_r + 23'd1;
      if (out_last_col) begin
        out_col_r  <= '0;
        out_row_r  <= out_row_r + 12'd1;
        out_ring_r <= (out_ring_r == RING_LAST) ? '0 : out_ring_r + 1'b1;
      end else begin
        out_col_r <= out_col_r + 1'b1;
      end
    end
  end

  // line store ring
  always_ff @(posedge clk) begin
    if (cmd.store && store_ok) mem[{in_ring_r, in_col_r}] <= pix_r;
    rd_r <= mem[{ring_rd, col_rd}];
  end

  // status
  always_comb begin
    sts.frame_open = open_r;
    sts.n_done     = !(s_r <= v_r);
    sts.hgt_last   = a_r == f_rx_r;
    if (in_cnt_r == f_total_r) sts.want_out = out_cnt_r < f_total_r;
    else sts.want_out = in_cnt_r > (23'(f_delay_r) + out_cnt_r);
    sts.scan_last  = (dy_r == $signed({2'b00, cur_h_r})) &&
                     (dx_r == $signed({2'b00, f_rx_r}));
    sts.out_free   = !out_valid_r || out_ready;
    sts.pend       = pend_r;
  end

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ===== src/elliptical_grayscale_erosion.sv =====
// Top level: configuration registers, controller and datapath of the elliptical erosion.
// Input: in_ready is high only while idle, so no new item is taken before the last one is done;
// a drain with no frame open is dropped at once. An item with an output due reads each window
// pixel (sum over columns of 2*h+1) in turn, as the line store has one read port, then emits.
// A frame-opening pixel first latches the settings, then finds per column 0..rx the truncated root.
// Reset (synchronous, rst_n low): no frame open, output empty, registers to their defaults.
`default_nettype none
module elliptical_grayscale_erosion
  import ege_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;
  reg_idx_t widx;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[4:2]);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rad_h        <= 4'd1;
      cfg_r.rad_v        <= 4'd1;
      cfg_r.edge_rep     <= 1'b0;
      cfg_r.frame_width  <= 12'd640;
      cfg_r.frame_height <= 12'd480;
    end else if (psel && penable && pwrite) begin
      case (widx)
        REG_RAD_H:        cfg_r.rad_h        <= pwdata[3:0];
        REG_RAD_V:        cfg_r.rad_v        <= pwdata[3:0];
        REG_EDGE_REP:     cfg_r.edge_rep     <= pwdata[0];
        REG_FRAME_WIDTH:  cfg_r.frame_width  <= pwdata[11:0];
        REG_FRAME_HEIGHT: cfg_r.frame_height <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (widx)
      REG_RAD_H:        prdata = {28'd0, cfg_r.rad_h};
      REG_RAD_V:        prdata = {28'd0, cfg_r.rad_v};
      REG_EDGE_REP:     prdata = {31'd0, cfg_r.edge_rep};
      REG_FRAME_WIDTH:  prdata = {20'd0, cfg_r.frame_width};
      REG_FRAME_HEIGHT: prdata = {20'd0, cfg_r.frame_height};
      default:          prdata = 32'd0;
    endcase
  end

  ege_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_drain (in_data.drain),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ege_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

  // a pixel, or any item of an open frame, closes the input in the cycle after it is taken
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (sts.frame_open || !in_data.drain) |=> !in_ready)
    else $error("input taken on consecutive cycles");

  // no window read is in flight while the block waits for an item
  a_idle_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !sts.pend)
    else $error("window read pending while idle");

  // a frame closes only by emitting its last result
  a_frame_close: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(sts.frame_open) |-> out_valid && out_data.frame_end)
    else $error("frame closed without a final result");

endmodule
`default_nettype wire

// ===== dv/elliptical_grayscale_erosion_test.sv =====
// Testbench for the elliptical erosion block: stimulus, predictor and result checking.
`default_nettype none
module elliptical_grayscale_erosion_test;
  import ege_pkg::*;

  localparam int LIMIT = 10000000;
  localparam int SETTLE = 1500;
  localparam int NROWS = 2 * MAX_RADIUS_Y + MAX_RADIUS_X + 2;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  elliptical_grayscale_erosion i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // pending stimulus and expected window minima
  in_item_t  pixel_q[$];
  out_item_t minima_q[$];
  int idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int results_seen = 0;
  int items_taken = 0;
  int frames_run = 0;
  int cycles = 0;

  // shadow registers
  logic [3:0]  sh_rx = 4'd1;
  logic [3:0]  sh_ry = 4'd1;
  logic        sh_edge = 1'b0;
  logic [11:0] sh_w = 12'd640;
  logic [11:0] sh_h = 12'd480;

  // predictor state
  logic [15:0] rows_px [NROWS][MAX_WIDTH];
  int  hgt [2 * MAX_RADIUS_X + 1];
  bit  open_f = 1'b0;
  int  fr_rx, fr_ry, fr_w, fr_h, fr_total, fr_delay, fr_in;
  bit  fr_edge;
  int  col_n, row_n, out_n;

  function automatic int clamp_to(int v, int hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  // column heights of the ellipse, exact integer rounding with ties to even
  function automatic void build_heights();
    longint a, t2, v, d, n, q;
    for (int i = 0; i < 2 * fr_rx + 1; i++) begin
      a = (i > fr_rx) ? i - fr_rx : fr_rx - i;
      t2 = (a == 0) ? 0 : (2 * a - 1) * (2 * a - 1);
      v = longint'(fr_ry) * fr_ry * (4 * longint'(fr_rx) * fr_rx - t2);
      d = 2 * fr_rx;
      n = 0;
      while (((n + 1) * d) * ((n + 1) * d) <= v) n++;
      q = (2 * n + 1) * fr_rx;
      if (q * q < v) n++;
      else if (q * q == v && n[0]) n++;
      hgt[i] = int'(n);
    end
  endfunction

  function automatic logic [15:0] sample_at(int r, int c);
    if (r < 0 || c < 0 || r >= fr_h || c >= fr_w) begin
      if (!fr_edge) return 16'd0;
      if (r < 0) r = 0;
      if (r >= fr_h) r = fr_h - 1;
      if (c < 0) c = 0;
      if (c >= fr_w) c = fr_w - 1;
    end
    return rows_px[r % NROWS][c % MAX_WIDTH];
  endfunction

  function automatic logic [15:0] window_min(int pos);
    int r, c, h;
    logic [15:0] m, v;
    r = pos / fr_w;
    c = pos % fr_w;
    m = 16'hFFFF;
    for (int dx = -fr_rx; dx <= fr_rx; dx++) begin
      h = hgt[dx + fr_rx];
      for (int dy = -h; dy <= h; dy++) begin
        v = sample_at(r + dy, c + dx);
        if (v < m) m = v;
      end
    end
    return m;
  endfunction

  // one accepted item: store the pixel and emit a minimum when one is due
  function automatic void erode_tick(in_item_t it);
    int avail;
    out_item_t res;
    if (!it.drain && !open_f) begin
      fr_rx = clamp_to(sh_rx, MAX_RADIUS_X);
      fr_ry = clamp_to(sh_ry, MAX_RADIUS_Y);
      fr_edge = sh_edge;
      fr_w = clamp_to(sh_w, MAX_WIDTH);
      fr_h = clamp_to(sh_h, 4095);
      fr_total = fr_w * fr_h;
      fr_delay = fr_ry * fr_w + fr_rx;
      fr_in = 0;
      col_n = 0;
      row_n = 0;
      out_n = 0;
      build_heights();
      open_f = 1'b1;
    end
    if (!open_f) return;
    if (!it.drain && fr_in < fr_total) begin
      rows_px[row_n % NROWS][col_n % MAX_WIDTH] = it.pixel_in;
      fr_in++;
      col_n++;
      if (col_n == fr_w) begin
        col_n = 0;
        row_n++;
      end
    end
    if (fr_in == fr_total) avail = fr_total;
    else avail = (fr_in > fr_delay) ? fr_in - fr_delay : 0;
    if (out_n >= avail) return;
    res.pixel_out = window_min(out_n);
    out_n++;
    res.frame_end = (out_n == fr_total);
    if (out_n == fr_total) open_f = 1'b0;
    minima_q.push_back(res);
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    mismatches++;
  endtask

  // driver: feeds pending items with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        erode_tick(in_data);
        items_taken++;
      end
      if (pixel_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pixel_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: random stalls, check each result against the oldest minimum
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (minima_q.size() == 0) begin
          report_mismatch($sformatf("unexpected item pixel_out=%0d frame_end=%0d",
                                    out_data.pixel_out, out_data.frame_end));
        end else begin
          out_item_t e;
          e = minima_q.pop_front();
          if (out_data.pixel_out !== e.pixel_out)
            report_mismatch($sformatf("pixel_out %0d, expected %0d",
                                      out_data.pixel_out, e.pixel_out));
          if (out_data.frame_end !== e.frame_end)
            report_mismatch($sformatf("frame_end %0d, expected %0d",
                                      out_data.frame_end, e.frame_end));
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_RAD_H:        sh_rx = val[3:0];
      REG_RAD_V:        sh_ry = val[3:0];
      REG_EDGE_REP:     sh_edge = val[0];
      REG_FRAME_WIDTH:  sh_w = val[11:0];
      REG_FRAME_HEIGHT: sh_h = val[11:0];
      default: ;
    endcase
  endtask

  // wait for the block to go idle, then let trailing work finish
  task automatic settle();
    while (pixel_q.size() > 0 || in_valid || minima_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_pixel();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'hF000 | 16'($urandom_range(4095));
      default: return 16'($urandom);
    endcase
  endfunction

  // one frame: registers, pixels with stray drains, then the flush drains
  task automatic run_frame(int rx, int ry, bit edge_on, int w, int h);
    int fw, fh, total, delay, flush;
    in_item_t it;
    settle();
    reg_write(REG_RAD_H, rx);
    reg_write(REG_RAD_V, ry);
    reg_write(REG_EDGE_REP, edge_on);
    reg_write(REG_FRAME_WIDTH, w);
    reg_write(REG_FRAME_HEIGHT, h);
    fw = clamp_to(w, MAX_WIDTH);
    fh = clamp_to(h, 4095);
    total = fw * fh;
    delay = clamp_to(ry, MAX_RADIUS_Y) * fw + clamp_to(rx, MAX_RADIUS_X);
    flush = total - (((total - 1 > delay) ? total - 1 - delay : 0) + 1);
    // drains while no frame is open do nothing
    if ($urandom_range(3) == 0) begin
      it.drain = 1'b1;
      it.pixel_in = 16'($urandom);
      pixel_q.push_back(it);
    end
    for (int i = 0; i < total; i++) begin
      if ($urandom_range(19) == 0) begin
        it.drain = 1'b1;
        it.pixel_in = 16'($urandom);
        pixel_q.push_back(it);
      end
      it.drain = 1'b0;
      it.pixel_in = pick_pixel();
      pixel_q.push_back(it);
    end
    // surplus pixels during the flush act as drains
    for (int i = 0; i < flush; i++) begin
      it.drain = ($urandom_range(4) != 0);
      it.pixel_in = 16'($urandom);
      pixel_q.push_back(it);
    end
    frames_run++;
  endtask

  initial begin
    int pix;
    int rx, ry, w, h;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed frames: register extremes, single pixel, edge modes
    run_frame(0, 0, 1'b0, 0, 0);
    run_frame(15, 15, 1'b1, 4, 3);
    run_frame(15, 15, 1'b0, 3, 2);
    run_frame(1, 15, 1'b1, 3, 5);
    run_frame(15, 1, 1'b0, 5, 2);
    run_frame(1, 1, 1'b1, 40, 1);
    run_frame(1, 1, 1'b0, 1, 40);
    run_frame(2, 3, 1'b1, 40, 2);

    // random frames over the idle and stall phases
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 84; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 84; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      pix = 0;
      while (pix < 175) begin
        if ($urandom_range(6) == 0) begin
          rx = $urandom_range(15, 5);
          ry = $urandom_range(15, 5);
          w = $urandom_range(4, 1);
          h = $urandom_range(4, 1);
        end else begin
          rx = $urandom_range(4, 0);
          ry = $urandom_range(4, 0);
          w = $urandom_range(12, 1);
          h = $urandom_range(8, 1);
        end
        run_frame(rx, ry, $urandom_range(1), w, h);
        pix += w * h;
      end
    end
    settle();

    $display("%0d frames, %0d items accepted, %0d results checked, %0d mismatches",
             frames_run, items_taken, results_seen, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
src/ege_pkg.sv
src/ege_ctrl.sv
src/ege_datapath.sv
src/elliptical_grayscale_erosion.sv
dv/elliptical_grayscale_erosion_test.sv
